### rtl/pol_pkg.sv
// Shared types and constants for the positional ordered list unit.
`default_nettype none

package pol_pkg;

  localparam int unsigned POL_DEPTH = 32;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start_asc;
    logic run_asc;
    logic start_desc;
    logic run_desc;
    logic place;
    logic set_err;
    logic clear_len;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_insert;
    logic is_delete;
    logic is_get;
    logic is_locate;
    logic is_clear;
    logic ins_ok;
    logic rd_ok;
    logic need_shift;
    logic len_zero;
    logic scan_done;
  } st_t;

endpackage

`default_nettype wire

### rtl/positional_ordered_list_unit.sv
// Top level of the positional ordered list unit: stream ports, controller and datapath.
//
//  channel  dir  fields (lowest bit up)                                   accepted when
//  s_axis   in   tuser: op[2:0]; tdata: position[5:0], value[37:6]        tvalid && tready
//  m_axis   out  tuser: status; tdata: data_out[31:0], found_at[37:32],  tvalid && tready
//                count[43:38], is_empty[44]
//
// One request is taken at a time; the next is taken as soon as the previous result sits in the
// output register, even while that result still waits to be collected.
// Clear, errors and locate on an empty list skip the walk; get reads one entry; delete walks the
// entries from the position to the end and insert from the end down to the position (an insert
// that appends at the end walks none); locate walks from the first entry until a match or the
// end; the single read port of the entry store walks one entry per cycle.
// Reset clears the length, so the list starts empty; the entry store itself is not cleared.
// A stalled output holds its result and the next result waits in the working result registers
// until the slot is free.
`default_nettype none

module positional_ordered_list_unit #(
  parameter int unsigned DEPTH = pol_pkg::POL_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request: tuser = op[2:0]; tdata = position[5:0], value[37:6], zeros[39:38]
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [pol_pkg::OP_W-1:0]        s_axis_tuser,
  input  wire logic [pol_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // result: tuser = status; tdata = data_out[31:0], found_at[37:32], count[43:38],
  //         is_empty[44], zeros[47:45]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic                                 m_axis_tuser,
  output logic      [pol_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned FOUND_LO = pol_pkg::VAL_W;
  localparam int unsigned COUNT_LO = FOUND_LO + pol_pkg::POS_W;
  localparam int unsigned EMPTY_B  = COUNT_LO + pol_pkg::CNT_W;

  pol_pkg::cmd_t cmd;
  pol_pkg::st_t  st;

  logic [pol_pkg::VAL_W-1:0] data_out;
  logic [pol_pkg::POS_W-1:0] found_at;
  logic [pol_pkg::CNT_W-1:0] count;
  logic                      is_empty;

  pol_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  pol_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .op_i       (s_axis_tuser),
    .position_i (s_axis_tdata[pol_pkg::POS_W-1:0]),
    .value_i    (s_axis_tdata[pol_pkg::POS_W +: pol_pkg::VAL_W]),
    .status_o   (m_axis_tuser),
    .data_out_o (data_out),
    .found_at_o (found_at),
    .count_o    (count),
    .is_empty_o (is_empty)
  );

  // pack the result fields, pad with zeros up to whole bytes
  always_comb begin
    m_axis_tdata                                  = '0;
    m_axis_tdata[pol_pkg::VAL_W-1:0]              = data_out;
    m_axis_tdata[FOUND_LO +: pol_pkg::POS_W]      = found_at;
    m_axis_tdata[COUNT_LO +: pol_pkg::CNT_W]      = count;
    m_axis_tdata[EMPTY_B]                         = is_empty;
  end

endmodule

`default_nettype wire

### rtl/pol_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/pol_ctrl.sv
// Controller state machine: sequences decode, scans, placement and result hand-off.
`default_nettype none

module pol_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire logic          m_ready_i,
  output logic               m_valid_o,
  input  wire pol_pkg::st_t  st_i,
  output pol_pkg::cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_ASC    = 6'b000100,
    S_DESC   = 6'b001000,
    S_PLACE  = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_ready_i;
    cmd_o     = '0;
    s_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st_i.is_insert) begin
          if (!st_i.ins_ok) begin
            cmd_o.set_err = 1'b1;
            state_d       = S_DONE;
          end else if (st_i.need_shift) begin
            cmd_o.start_desc = 1'b1;
            state_d          = S_DESC;
          end else begin
            state_d = S_PLACE;
          end
        end else if (st_i.is_delete || st_i.is_get) begin
          if (st_i.rd_ok) begin
            cmd_o.start_asc = 1'b1;
            state_d         = S_ASC;
          end else begin
            cmd_o.set_err = 1'b1;
            state_d       = S_DONE;
          end
        end else if (st_i.is_locate) begin
          if (st_i.len_zero) begin
            state_d = S_DONE;
          end else begin
            cmd_o.start_asc = 1'b1;
            state_d         = S_ASC;
          end
        end else if (st_i.is_clear) begin
          cmd_o.clear_len = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.set_err = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_ASC: begin
        cmd_o.run_asc = 1'b1;
        if (st_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DESC: begin
        cmd_o.run_desc = 1'b1;
        if (st_i.scan_done) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output slot is free
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

`default_nettype wire

### rtl/pol_dp.sv
// Datapath: request and result registers, length, scan pointers and the entry store.
`default_nettype none

module pol_dp #(
  parameter int unsigned DEPTH = pol_pkg::POL_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pol_pkg::cmd_t               cmd_i,
  output pol_pkg::st_t                     st_o,
  input  wire logic [pol_pkg::OP_W-1:0]    op_i,
  input  wire logic [pol_pkg::POS_W-1:0]   position_i,
  input  wire logic [pol_pkg::VAL_W-1:0]   value_i,
  output logic                             status_o,
  output logic      [pol_pkg::VAL_W-1:0]   data_out_o,
  output logic      [pol_pkg::POS_W-1:0]   found_at_o,
  output logic      [pol_pkg::CNT_W-1:0]   count_o,
  output logic                             is_empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = ((LW > pol_pkg::POS_W) ? LW : pol_pkg::POS_W) + 1;

  // request
  logic [pol_pkg::OP_W-1:0]  op_q;
  logic [pol_pkg::POS_W-1:0] pos_q;
  logic [pol_pkg::VAL_W-1:0] val_q;

  // control state
  logic [LW-1:0] len_q, len_d;
  logic          issuing_q, issuing_d;
  logic          pend_q, pend_d;

  // scan addresses
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] last_q;
  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] end_q, end_d;

  // working result and output register
  logic                      res_status_q, res_status_d;
  logic [pol_pkg::VAL_W-1:0] res_data_q, res_data_d;
  logic [pol_pkg::POS_W-1:0] res_found_q, res_found_d;
  logic                      out_status_q;
  logic [pol_pkg::VAL_W-1:0] out_data_q;
  logic [pol_pkg::POS_W-1:0] out_found_q;
  logic [pol_pkg::CNT_W-1:0] out_count_q;
  logic                      out_empty_q;

  // memory port
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [pol_pkg::VAL_W-1:0] wdata;
  logic [pol_pkg::VAL_W-1:0] rdata;

  logic [CW-1:0] pos_x, len_x, found_x;
  logic [AW-1:0] pos_adr, len_adr;
  logic          match_hit, scan_done, running;

  assign pos_x   = CW'(pos_q);
  assign len_x   = CW'(len_q);
  assign pos_adr = AW'(pos_x - CW'(1));
  assign len_adr = AW'(len_x - CW'(1));
  assign found_x = CW'(last_q) + CW'(1);
  assign running = cmd_i.run_asc || cmd_i.run_desc;

  assign match_hit = (op_q == pol_pkg::OP_LOCATE) && (rdata == val_q);
  assign scan_done = pend_q && ((last_q == end_q) || match_hit);

  always_comb begin
    st_o            = '0;
    st_o.is_insert  = (op_q == pol_pkg::OP_INSERT);
    st_o.is_delete  = (op_q == pol_pkg::OP_DELETE);
    st_o.is_get     = (op_q == pol_pkg::OP_GET);
    st_o.is_locate  = (op_q == pol_pkg::OP_LOCATE);
    st_o.is_clear   = (op_q == pol_pkg::OP_CLEAR);
    st_o.ins_ok     = (pos_q != '0) && (pos_x <= len_x + CW'(1)) && (len_q != LW'(DEPTH));
    st_o.rd_ok      = (pos_q != '0) && (pos_x <= len_x);
    st_o.need_shift = (len_x >= pos_x);
    st_o.len_zero   = (len_q == '0);
    st_o.scan_done  = scan_done;
  end

  // scan pointers, length and working result
  always_comb begin
    len_d        = len_q;
    issuing_d    = issuing_q;
    pend_d       = running && issuing_q;
    ptr_d        = ptr_q;
    start_d      = start_q;
    end_d        = end_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_found_d  = res_found_q;
    we           = 1'b0;
    waddr        = pos_adr;
    wdata        = val_q;

    if (cmd_i.load) begin
      res_status_d = 1'b0;
      res_data_d   = '0;
      res_found_d  = '0;
    end
    if (cmd_i.set_err) begin
      res_status_d = 1'b1;
    end
    if (cmd_i.clear_len) begin
      len_d = '0;
    end

    if (cmd_i.start_asc) begin
      start_d   = (op_q == pol_pkg::OP_LOCATE) ? '0 : pos_adr;
      end_d     = (op_q == pol_pkg::OP_GET) ? pos_adr : len_adr;
      ptr_d     = start_d;
      issuing_d = 1'b1;
    end
    if (cmd_i.start_desc) begin
      start_d   = len_adr;
      end_d     = pos_adr;
      ptr_d     = len_adr;
      issuing_d = 1'b1;
    end

    // ascending walk: read ahead one entry, act on its registered read data in the next cycle
    if (cmd_i.run_asc) begin
      if (issuing_q) begin
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == end_q) begin
          issuing_d = 1'b0;
        end
      end
      if (pend_q) begin
        if (match_hit) begin
          res_found_d = found_x[pol_pkg::POS_W-1:0];
        end
        if ((op_q != pol_pkg::OP_LOCATE) && (last_q == start_q)) begin
          res_data_d = rdata;
        end
        if ((op_q == pol_pkg::OP_DELETE) && (last_q != start_q)) begin
          we    = 1'b1;
          waddr = last_q - AW'(1);
          wdata = rdata;
        end
        if ((op_q == pol_pkg::OP_DELETE) && scan_done) begin
          len_d = len_q - LW'(1);
        end
      end
    end

    // descending walk: move each entry up by one place
    if (cmd_i.run_desc) begin
      if (issuing_q) begin
        ptr_d = ptr_q - AW'(1);
        if (ptr_q == end_q) begin
          issuing_d = 1'b0;
        end
      end
      if (pend_q) begin
        we    = 1'b1;
        waddr = last_q + AW'(1);
        wdata = rdata;
      end
    end

    if (cmd_i.place) begin
      we    = 1'b1;
      waddr = pos_adr;
      wdata = val_q;
      len_d = len_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      issuing_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      len_q     <= len_d;
      issuing_q <= issuing_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    ptr_q        <= ptr_d;
    last_q       <= ptr_q;
    start_q      <= start_d;
    end_q        <= end_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_found_q  <= res_found_d;
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_found_q  <= res_found_q;
      out_count_q  <= len_x[pol_pkg::CNT_W-1:0];
      out_empty_q  <= (len_q == '0);
    end
  end

  pol_ram #(
    .WIDTH (pol_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  assign status_o   = out_status_q;
  assign data_out_o = out_data_q;
  assign found_at_o = out_found_q;
  assign count_o    = out_count_q;
  assign is_empty_o = out_empty_q;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(DEPTH))
    else $error("list length beyond depth");

  a_write_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(waddr) <= len_x))
    else $error("store write outside the list");

  a_place_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |=> (len_q == $past(len_q) + LW'(1)))
    else $error("placement did not grow the list");

  a_walk_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running && pend_q && !issuing_q) |-> scan_done)
    else $error("walk ran past its last entry");

endmodule

`default_nettype wire

### test/tb_positional_ordered_list_unit.sv
// Self-checking stream testbench for the positional ordered list unit.
`default_nettype none

module tb_positional_ordered_list_unit;

  // Op codes past the last defined operation; the block must answer them with an error.
  localparam logic [pol_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [pol_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [pol_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1525;
  localparam int unsigned LONG_HOLD    = 500;   // receiver hold-off to back the block up
  localparam int unsigned STUCK_LIMIT  = 4000;  // cycles without any handshake
  localparam int unsigned DRAIN_CYCLES = 64;    // extra clocks after the last result is checked

  typedef struct packed {
    logic [pol_pkg::OP_W-1:0]  op;
    logic [pol_pkg::POS_W-1:0] position;
    logic [pol_pkg::VAL_W-1:0] value;
  } list_request_t;

  typedef struct packed {
    logic                      status;
    logic [pol_pkg::VAL_W-1:0] data_out;
    logic [pol_pkg::POS_W-1:0] found_at;
    logic [pol_pkg::CNT_W-1:0] count;
    logic                      is_empty;
  } list_result_t;

  typedef struct {
    list_request_t rq;
    bit            typed;
    list_result_t  want;
  } directed_row_t;

  typedef enum {MIX_OPS, FILL_UP, DRAIN_DOWN} stim_mode_e;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [pol_pkg::OP_W-1:0]      s_axis_tuser  = '0;
  logic [pol_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic                          m_axis_tuser;
  logic [pol_pkg::M_TDATA_W-1:0] m_axis_tdata;

  // Predicted list contents, updated as each request is accepted
  logic [pol_pkg::VAL_W-1:0] list_store [pol_pkg::POL_DEPTH];
  int unsigned               list_len;

  list_result_t  pending_results [$];
  directed_row_t directed_rows [$];
  int unsigned   fail_count;
  bit            quiet_phase;
  bit            hold_output_long;

  positional_ordered_list_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one request to the predicted list and return the result it must produce.
  function automatic list_result_t apply_list_op(input list_request_t rq);
    list_result_t res;
    int           pos;
    int           k;
    res = '0;
    pos = int'(rq.position);
    case (rq.op)
      pol_pkg::OP_INSERT: begin
        if (pos == 0 || pos > int'(list_len) + 1 || list_len >= pol_pkg::POL_DEPTH) begin
          res.status = 1'b1;
        end else begin
          for (k = int'(list_len); k >= pos; k--) list_store[k] = list_store[k-1];
          list_store[pos-1] = rq.value;
          list_len++;
        end
      end
      pol_pkg::OP_DELETE: begin
        if (pos == 0 || pos > int'(list_len)) begin
          res.status = 1'b1;
        end else begin
          res.data_out = list_store[pos-1];
          for (k = pos; k < int'(list_len); k++) list_store[k-1] = list_store[k];
          list_len--;
        end
      end
      pol_pkg::OP_GET: begin
        if (pos == 0 || pos > int'(list_len)) res.status = 1'b1;
        else res.data_out = list_store[pos-1];
      end
      pol_pkg::OP_LOCATE: begin
        // first match wins, so later matches are ignored once found_at is set
        for (k = 0; k < int'(list_len); k++) begin
          if (res.found_at == '0 && list_store[k] == rq.value) begin
            res.found_at = pol_pkg::POS_W'(k + 1);
          end
        end
      end
      pol_pkg::OP_CLEAR: begin
        list_len = 0;
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    res.count    = pol_pkg::CNT_W'(list_len);
    res.is_empty = (list_len == 0);
    return res;
  endfunction

  function automatic list_result_t list_outcome(input logic status, input logic [31:0] data,
                                                input int unsigned found,
                                                input int unsigned count);
    list_result_t res;
    res.status   = status;
    res.data_out = data;
    res.found_at = pol_pkg::POS_W'(found);
    res.count    = pol_pkg::CNT_W'(count);
    res.is_empty = (count == 0);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a quiet phase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [pol_pkg::VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    if (r < 65) return $urandom_range(0, 7);     // small range so duplicates occur
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    if (list_len != 0) return list_store[$urandom_range(0, list_len - 1)];
    return $urandom();
  endfunction

  // Mostly in-range positions, the rest anywhere in the field.
  function automatic logic [pol_pkg::POS_W-1:0] pick_position(input int unsigned top);
    if (top != 0 && $urandom_range(0, 99) < 85) return pol_pkg::POS_W'($urandom_range(1, top));
    return pol_pkg::POS_W'($urandom_range(0, 63));
  endfunction

  function automatic list_request_t next_random_request(input stim_mode_e mode);
    list_request_t rq;
    int unsigned   r;
    rq.value = pick_value();
    case (mode)
      FILL_UP: begin
        rq.op       = pol_pkg::OP_INSERT;
        rq.position = pol_pkg::POS_W'($urandom_range(1, list_len + 1));
      end
      DRAIN_DOWN: begin
        rq.op       = pol_pkg::OP_DELETE;
        rq.position = (list_len != 0) ? pol_pkg::POS_W'($urandom_range(1, list_len))
                                      : pol_pkg::POS_W'($urandom_range(0, 63));
      end
      default: begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          rq.op       = pol_pkg::OP_INSERT;
          rq.position = pick_position(list_len + 1);
        end else if (r < 45) begin
          rq.op       = pol_pkg::OP_DELETE;
          rq.position = pick_position(list_len);
        end else if (r < 65) begin
          rq.op       = pol_pkg::OP_GET;
          rq.position = pick_position(list_len);
        end else if (r < 90) begin
          rq.op       = pol_pkg::OP_LOCATE;
          rq.position = pol_pkg::POS_W'($urandom_range(0, 63));
          if (list_len != 0 && $urandom_range(0, 9) < 7) begin
            rq.value = list_store[$urandom_range(0, list_len - 1)];
          end
        end else if (r < 93) begin
          rq.op       = pol_pkg::OP_CLEAR;
          rq.position = pol_pkg::POS_W'($urandom_range(0, 63));
        end else begin
          rq.op       = pol_pkg::OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
          rq.position = pol_pkg::POS_W'($urandom_range(0, 63));
        end
      end
    endcase
    return rq;
  endfunction

  task automatic add_row(input logic [pol_pkg::OP_W-1:0] op, input int unsigned pos,
                         input logic [31:0] value, input bit typed, input list_result_t want);
    directed_row_t row;
    row.rq.op       = op;
    row.rq.position = pol_pkg::POS_W'(pos);
    row.rq.value    = value;
    row.typed       = typed;
    row.want        = want;
    directed_rows.push_back(row);
  endtask

  // Offer one request after a random gap and hold it until the block takes it.
  task automatic send_request(input list_request_t rq, input bit typed,
                              input list_result_t want);
    list_result_t predicted;
    int unsigned  gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.op;
    s_axis_tdata  <= {2'b00, rq.value, rq.position};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_list_op(rq);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic report_mismatch(input string field, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("MISMATCH at %0t: %s got %0h, want %0h", $time, field, got, want);
    fail_count++;
  endtask

  task automatic check_list_result(input list_result_t got);
    list_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending", 48'(got), '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)     report_mismatch("status", got.status, want.status);
    if (got.data_out !== want.data_out) report_mismatch("data_out", got.data_out, want.data_out);
    if (got.found_at !== want.found_at) report_mismatch("found_at", got.found_at, want.found_at);
    if (got.count !== want.count)       report_mismatch("count", got.count, want.count);
    if (got.is_empty !== want.is_empty) report_mismatch("is_empty", got.is_empty, want.is_empty);
  endtask

  // Unpack each collected result and compare it with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_list_result({m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[37:32],
                         m_axis_tdata[43:38], m_axis_tdata[44]});
    end
  end

  // Result side: open for a while, then stall; honour one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned open_left;
    stall_left = 0;
    open_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_output_long) begin
        hold_output_long = 1'b0;
        stall_left       = LONG_HOLD;
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (open_left != 0) begin
          open_left--;
        end else begin
          stall_left = pick_gap();
          open_left  = $urandom_range(0, 30);
        end
      end
    end
  end

  // End the run when neither side has moved for far longer than any legal stall.
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stuck = 0;
      else stuck++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    stim_mode_e  mode;
    int unsigned mode_left;
    int unsigned sent;
    fail_count       = 0;
    quiet_phase      = 1'b0;
    hold_output_long = 1'b0;
    list_len         = 0;
    mode             = MIX_OPS;
    mode_left        = 0;
    sent             = 0;

    // Directed part: empty list, bounds, extremes, duplicates, spare op codes, clear.
    add_row(pol_pkg::OP_GET,    1, 32'h0,         1, list_outcome(1, 32'h0, 0, 0));
    add_row(pol_pkg::OP_DELETE, 1, 32'h0,         1, list_outcome(1, 32'h0, 0, 0));
    add_row(pol_pkg::OP_LOCATE, 0, 32'h0,         1, list_outcome(0, 32'h0, 0, 0));
    add_row(pol_pkg::OP_INSERT, 0, 32'h5,         1, list_outcome(1, 32'h0, 0, 0));
    add_row(pol_pkg::OP_INSERT, 2, 32'h5,         1, list_outcome(1, 32'h0, 0, 0));
    add_row(pol_pkg::OP_INSERT, 1, 32'h8000_0000, 1, list_outcome(0, 32'h0, 0, 1));
    add_row(pol_pkg::OP_INSERT, 2, 32'h7FFF_FFFF, 1, list_outcome(0, 32'h0, 0, 2));
    add_row(pol_pkg::OP_INSERT, 1, 32'hFFFF_FFFF, 1, list_outcome(0, 32'h0, 0, 3));
    add_row(pol_pkg::OP_INSERT, 4, 32'h0,         1, list_outcome(0, 32'h0, 0, 4));
    add_row(pol_pkg::OP_INSERT, 6, 32'h1,         1, list_outcome(1, 32'h0, 0, 4));
    add_row(pol_pkg::OP_GET,    1, 32'h0,         1, list_outcome(0, 32'hFFFF_FFFF, 0, 4));
    add_row(pol_pkg::OP_GET,    63, 32'h0,        1, list_outcome(1, 32'h0, 0, 4));
    add_row(pol_pkg::OP_GET,    0, 32'h0,         1, list_outcome(1, 32'h0, 0, 4));
    add_row(pol_pkg::OP_LOCATE, 0, 32'h7FFF_FFFF, 1, list_outcome(0, 32'h0, 3, 4));
    add_row(pol_pkg::OP_LOCATE, 0, 32'h1234,      1, list_outcome(0, 32'h0, 0, 4));
    add_row(pol_pkg::OP_INSERT, 1, 32'h0,         1, list_outcome(0, 32'h0, 0, 5));
    add_row(pol_pkg::OP_LOCATE, 0, 32'h0,         1, list_outcome(0, 32'h0, 1, 5));
    add_row(pol_pkg::OP_DELETE, 5, 32'h0,         1, list_outcome(0, 32'h0, 0, 4));
    add_row(pol_pkg::OP_DELETE, 2, 32'h0,         1, list_outcome(0, 32'hFFFF_FFFF, 0, 3));
    add_row(OP_RSVD5,           1, 32'hFFFF_FFFF, 1, list_outcome(1, 32'h0, 0, 3));
    add_row(OP_RSVD6,           2, 32'h0,         1, list_outcome(1, 32'h0, 0, 3));
    add_row(OP_RSVD7,           63, 32'h8000_0000, 1, list_outcome(1, 32'h0, 0, 3));
    add_row(pol_pkg::OP_CLEAR,  0, 32'h0,         1, list_outcome(0, 32'h0, 0, 0));
    add_row(pol_pkg::OP_INSERT, 1, 32'hA5A5_5A5A, 0, '0);
    add_row(pol_pkg::OP_LOCATE, 0, 32'hA5A5_5A5A, 0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
    end

    // Back the block up once: hold results off while requests keep coming.
    hold_output_long = 1'b1;

    // Random part in episodes: fill to full and beyond, drain to empty and beyond, or mix.
    while (sent < RANDOM_ITEMS) begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: begin
            mode      = FILL_UP;
            mode_left = pol_pkg::POL_DEPTH - list_len + $urandom_range(1, 3);
          end
          4, 5, 6: begin
            mode      = DRAIN_DOWN;
            mode_left = list_len + $urandom_range(1, 3);
          end
          default: begin
            mode      = MIX_OPS;
            mode_left = $urandom_range(20, 60);
          end
        endcase
        quiet_phase = ($urandom_range(0, 5) == 0);
      end
      send_request(next_random_request(mode), 0, '0);
      sent++;
      mode_left--;
    end
    s_axis_tvalid <= 1'b0;
    quiet_phase = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

### positional_ordered_list_unit.f
rtl/pol_pkg.sv
rtl/pol_ram.sv
rtl/pol_ctrl.sv
rtl/pol_dp.sv
rtl/positional_ordered_list_unit.sv
test/tb_positional_ordered_list_unit.sv
